// ===== sv/two_sided_butterfly_transform_unit_macros.svh =====
// Assertion macros shared by the butterfly transform RTL
`ifndef TWO_SIDED_BUTTERFLY_TRANSFORM_UNIT_MACROS_SVH
`define TWO_SIDED_BUTTERFLY_TRANSFORM_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define TSBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TSBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tsbt_pkg.sv =====
// Shared widths, opcodes, status codes and register indexes
`default_nettype none
package tsbt_pkg;

  localparam int OPCODE_W  = 3;
  localparam int IDX_W     = 6;
  localparam int DATA_W    = 32;
  localparam int BF_W      = 18;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W     = DATA_W + 2;
  localparam int PROD_W    = 2 * BF_W;

  localparam logic [OPCODE_W-1:0] OP_LOAD_MAT   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_LEFT  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_LOAD_RIGHT = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_RUN        = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_VALUE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 1'b1;

endpackage
`default_nettype wire

// ===== sv/tsbt_channels.sv =====
// Command and response channel interfaces
`default_nettype none
interface tsbt_cmd_if import tsbt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [IDX_W-1:0]           row_index;
  logic [IDX_W-1:0]           column_index;
  logic signed [DATA_W-1:0]   data_value;

  modport source (output valid, opcode, row_index, column_index, data_value, input ready);
  modport sink (input valid, opcode, row_index, column_index, data_value, output ready);
endinterface

interface tsbt_rsp_if import tsbt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   read_value;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface
`default_nettype wire

// ===== sv/two_sided_butterfly_transform_unit.sv =====
// Top level: two-sided butterfly transform on a fixed-point matrix held in RAM
//
//  channel | dir | handshake        | beat payload
//  --------+-----+------------------+-------------------------------------------
//  cmd     | in  | valid/ready      | opcode, row_index, column_index, data_value
//  rsp     | out | valid/ready      | read_value, status
//  cfg     | in  | cfg_wen (no wait)| cfg_addr, cfg_wdata
//
//  Loads put their result in the pending slot at once, reads go through the RAM
//  read, then the result slot. A run spends a check step per loop step, and per
//  butterfly four back-to-back reads of the single matrix read port, then four
//  outputs through the scaling pipe.
//  Reset (rst, synchronous) clears control only; RAM contents stay undefined.
//  One result may wait in rsp while the next command is taken; cmd stalls
//  while that second result is held.
`default_nettype none
`include "two_sided_butterfly_transform_unit_macros.svh"
module two_sided_butterfly_transform_unit import tsbt_pkg::*; #(
  parameter int MAX_SIZE  = 64,
  parameter int MAX_DEPTH = 6
) (
  input  wire                  clk,
  input  wire                  rst,
  tsbt_cmd_if.sink             cmd,
  tsbt_rsp_if.source           rsp,
  input  wire                  cfg_wen,
  input  wire [CFG_IDX_W-1:0]  cfg_addr,
  input  wire [CFG_W-1:0]      cfg_wdata
);

  localparam int AW   = $clog2(MAX_SIZE * MAX_SIZE);
  localparam int BAW  = $clog2(MAX_SIZE * MAX_DEPTH);
  localparam int SW   = $clog2(MAX_SIZE + 1);
  localparam int LW   = $clog2(MAX_DEPTH + 1);
  localparam int CW0  = $clog2(MAX_SIZE + (1 << MAX_DEPTH)) + 2;
  localparam int CW   = (CW0 > IDX_W) ? CW0 : IDX_W;
  localparam int TW   = AW + 1;
  localparam int SIZE_RST = (MAX_SIZE < 64) ? MAX_SIZE : 64;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDW  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MAC  = 3'd4;

  localparam logic [2:0] RD_LAST  = 3'd4;
  localparam logic [2:0] MAC_LAST = 3'd5;

  // Configuration and control state
  logic [SW-1:0]  size, size_cfg;
  logic [LW-1:0]  depth, depth_cfg;
  logic [2:0]     state;
  logic [2:0]     cnt;
  logic [LW-1:0]  k;
  logic [CW-1:0]  orow, ocol, i, j, blk, nd;
  logic           pvalid, ovalid;

  // Datapath registers
  logic signed [DATA_W-1:0] a_q [4];
  logic signed [BF_W-1:0]   r_q [2];
  logic signed [BF_W-1:0]   s_q [2];
  logic [1:0]               prev_c;
  logic                     prev_ok, prev_lok, prev_rok;
  logic                     rd_ok;
  logic [STATUS_W-1:0]      rd_status;
  logic signed [DATA_W-1:0] pend_value, out_value;
  logic [STATUS_W-1:0]      pend_status, out_status;

  // Decode
  logic                 accept, move;
  logic [CW-1:0]        size_x, depth_x, row_x, col_x;
  logic                 mat_in, bf_in, val_in;
  logic [STATUS_W-1:0]  cmd_status;
  logic [AW-1:0]        cmd_maddr;
  logic [BAW-1:0]       cmd_baddr;
  logic [CW-1:0]        two, nd_init, blk_init;

  // Loop geometry
  logic [CW-1:0]  h, ra, rb, ca, cb;
  logic           row_end, col_end, last_col, last_row, last_lvl, run_done;
  logic [CW-1:0]  rrow, rcol, lrow, vcol;
  logic [AW-1:0]  run_maddr;
  logic [BAW-1:0] laddr, vaddr;
  logic           rd_in, l_in, v_in;

  // Scaling pipe interface
  logic                     sc_valid, sc_out_valid;
  logic [1:0]               q;
  logic signed [SUM_W-1:0]  e00, e01, e10, e11, sum;
  logic signed [BF_W-1:0]   r_sel, s_sel;
  logic [CW-1:0]            wrow, wcol;
  logic [TW-1:0]            sc_tag, sc_tag_out;
  logic signed [DATA_W-1:0] sc_result;

  // RAM ports
  logic                 m_we, l_we, v_we;
  logic [AW-1:0]        m_waddr, m_raddr;
  logic [DATA_W-1:0]    m_wdata, m_rdata;
  logic [BF_W-1:0]      l_rdata, v_rdata;

  // Pending result slot
  logic                     pset;
  logic signed [DATA_W-1:0] pset_value;
  logic [STATUS_W-1:0]      pset_status;

  // Clamp register writes into their legal ranges
  always_comb begin
    if (cfg_wdata == '0) begin
      size_cfg = SW'(1);
    end else if (int'(cfg_wdata) > MAX_SIZE) begin
      size_cfg = SW'(MAX_SIZE);
    end else begin
      size_cfg = SW'(cfg_wdata);
    end
    if (cfg_wdata[2:0] == '0) begin
      depth_cfg = LW'(1);
    end else if (int'(cfg_wdata[2:0]) > MAX_DEPTH) begin
      depth_cfg = LW'(MAX_DEPTH);
    end else begin
      depth_cfg = LW'(cfg_wdata[2:0]);
    end
  end

  assign cmd.ready = (state == S_IDLE) && !pvalid;
  assign accept    = cmd.valid && cmd.ready;
  assign move      = !ovalid || rsp.ready;

  assign size_x  = CW'(size);
  assign depth_x = CW'(depth);
  assign row_x   = CW'(cmd.row_index);
  assign col_x   = CW'(cmd.column_index);
  assign mat_in  = (row_x < size_x) && (col_x < size_x);
  assign bf_in   = (row_x < size_x) && (col_x < depth_x);
  assign val_in  = cmd.data_value[DATA_W-1:BF_W-1] ==
                   {(DATA_W-BF_W+1){cmd.data_value[BF_W-1]}};
  assign cmd_maddr = AW'(row_x * MAX_SIZE + col_x);
  assign cmd_baddr = BAW'(row_x * MAX_DEPTH + col_x);

  always_comb begin
    case (cmd.opcode)
      OP_LOAD_MAT, OP_READ: cmd_status = mat_in ? ST_OK : ST_INDEX;
      OP_LOAD_LEFT, OP_LOAD_RIGHT: begin
        if (!bf_in) begin
          cmd_status = ST_INDEX;
        end else if (!val_in) begin
          cmd_status = ST_VALUE;
        end else begin
          cmd_status = ST_OK;
        end
      end
      OP_RUN:  cmd_status = ST_OK;
      default: cmd_status = ST_INDEX;
    endcase
  end

  // Logical size rounds up to a multiple of 2^depth; level 0 blocks are nd >> (depth-1)
  assign two      = CW'(1) << depth;
  assign nd_init  = (size_x + two - CW'(1)) & ~(two - CW'(1));
  assign blk_init = nd_init >> (depth - LW'(1));

  assign h  = blk >> 1;
  assign ra = orow + i;
  assign rb = ra + h;
  assign ca = ocol + j;
  assign cb = ca + h;

  assign row_end  = (i == h) || (ra >= size_x);
  assign col_end  = (j == h) || (ca >= size_x);
  assign last_col = (ocol + blk) == nd;
  assign last_row = (orow + blk) == nd;
  assign last_lvl = (k + LW'(1)) == depth;
  assign run_done = (state == S_CHK) && row_end && last_col && last_row && last_lvl;

  // Read schedule: cnt picks the corner; butterfly entries on the first two reads
  assign rrow      = cnt[1] ? rb : ra;
  assign rcol      = cnt[0] ? cb : ca;
  assign rd_in     = (rrow < size_x) && (rcol < size_x);
  assign run_maddr = AW'(rrow * MAX_SIZE + rcol);
  assign lrow      = cnt[0] ? rb : ra;
  assign vcol      = cnt[0] ? cb : ca;
  assign l_in      = lrow < size_x;
  assign v_in      = vcol < size_x;
  assign laddr     = BAW'(lrow * MAX_DEPTH + k);
  assign vaddr     = BAW'(vcol * MAX_DEPTH + k);

  // Four outputs per butterfly; q picks the sign pattern and the entry pair
  assign sc_valid = (state == S_MAC) && !cnt[2];
  assign q        = cnt[1:0];
  assign e00      = SUM_W'(a_q[0]);
  assign e01      = SUM_W'(a_q[1]);
  assign e10      = SUM_W'(a_q[2]);
  assign e11      = SUM_W'(a_q[3]);
  assign sum      = e00 + (q[0] ? -e01 : e01) + (q[1] ? -e10 : e10)
                  + ((q[0] ^ q[1]) ? -e11 : e11);
  assign r_sel    = q[1] ? r_q[1] : r_q[0];
  assign s_sel    = q[0] ? s_q[1] : s_q[0];
  assign wrow     = q[1] ? rb : ra;
  assign wcol     = q[0] ? cb : ca;
  assign sc_tag   = {(wrow < size_x) && (wcol < size_x), AW'(wrow * MAX_SIZE + wcol)};

  tsbt_scale #(.TW(TW)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .sum       (sum),
    .r         (r_sel),
    .s         (s_sel),
    .tag_in    (sc_tag),
    .out_valid (sc_out_valid),
    .result    (sc_result),
    .tag_out   (sc_tag_out)
  );

  // Matrix RAM is shared between command access and the run
  assign m_we    = (accept && (cmd.opcode == OP_LOAD_MAT) && mat_in)
                || (sc_out_valid && sc_tag_out[TW-1]);
  assign m_waddr = (state == S_IDLE) ? cmd_maddr : sc_tag_out[AW-1:0];
  assign m_wdata = (state == S_IDLE) ? cmd.data_value : sc_result;
  assign m_raddr = (state == S_IDLE) ? cmd_maddr : run_maddr;

  assign l_we = accept && (cmd.opcode == OP_LOAD_LEFT) && bf_in && val_in;
  assign v_we = accept && (cmd.opcode == OP_LOAD_RIGHT) && bf_in && val_in;

  tsbt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE * MAX_SIZE)) u_mat_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  tsbt_ram #(.WIDTH(BF_W), .DEPTH(MAX_SIZE * MAX_DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (cmd_baddr),
    .wdata (cmd.data_value[BF_W-1:0]),
    .raddr (laddr),
    .rdata (l_rdata)
  );

  tsbt_ram #(.WIDTH(BF_W), .DEPTH(MAX_SIZE * MAX_DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (cmd_baddr),
    .wdata (cmd.data_value[BF_W-1:0]),
    .raddr (vaddr),
    .rdata (v_rdata)
  );

  // Result into the pending slot: loads and unknown opcodes at once, reads after the RAM, runs at the end
  always_comb begin
    pset        = 1'b0;
    pset_value  = '0;
    pset_status = ST_OK;
    if (accept && (cmd.opcode != OP_READ) && (cmd.opcode != OP_RUN)) begin
      pset        = 1'b1;
      pset_status = cmd_status;
    end else if (state == S_RDW) begin
      pset        = 1'b1;
      pset_value  = rd_ok ? $signed(m_rdata) : '0;
      pset_status = rd_status;
    end else if (run_done) begin
      pset = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size   <= SW'(SIZE_RST);
      depth  <= LW'(1);
      state  <= S_IDLE;
      cnt    <= '0;
      pvalid <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_addr)
          REG_SIZE:  size  <= size_cfg;
          REG_DEPTH: depth <= depth_cfg;
          default: ;
        endcase
      end

      // Advance the pending result into the output register
      if (move) begin
        ovalid <= pvalid;
      end
      if (pset) begin
        pvalid <= 1'b1;
      end else if (move) begin
        pvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept && (cmd.opcode == OP_READ)) begin
            state <= S_RDW;
          end else if (accept && (cmd.opcode == OP_RUN)) begin
            nd    <= nd_init;
            blk   <= blk_init;
            k     <= '0;
            orow  <= '0;
            ocol  <= '0;
            i     <= '0;
            j     <= '0;
            state <= S_CHK;
          end
        end
        S_RDW: state <= S_IDLE;
        S_CHK: begin
          if (row_end) begin
            // Block finished: step column block, then row block, then level
            i <= '0;
            j <= '0;
            if (!last_col) begin
              ocol <= ocol + blk;
            end else begin
              ocol <= '0;
              if (!last_row) begin
                orow <= orow + blk;
              end else begin
                orow <= '0;
                if (last_lvl) begin
                  state <= S_IDLE;
                end else begin
                  k   <= k + LW'(1);
                  blk <= blk << 1;
                end
              end
            end
          end else if (col_end) begin
            j <= '0;
            i <= i + CW'(1);
          end else begin
            cnt   <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (cnt == RD_LAST) begin
            cnt   <= '0;
            state <= S_MAC;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_MAC: begin
          if (cnt == MAC_LAST) begin
            cnt   <= '0;
            j     <= j + CW'(1);
            state <= S_CHK;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload: capture operands in the cycle after each read, out-of-range reads as zero
  always_ff @(posedge clk) begin
    prev_c   <= cnt[1:0];
    prev_ok  <= rd_in;
    prev_lok <= l_in;
    prev_rok <= v_in;
    if (accept) begin
      rd_ok     <= mat_in;
      rd_status <= cmd_status;
    end
    if ((state == S_RD) && (cnt != '0)) begin
      a_q[prev_c] <= prev_ok ? $signed(m_rdata) : '0;
      if (!prev_c[1]) begin
        r_q[prev_c[0]] <= prev_lok ? $signed(l_rdata) : '0;
        s_q[prev_c[0]] <= prev_rok ? $signed(v_rdata) : '0;
      end
    end
    if (pset) begin
      pend_value  <= pset_value;
      pend_status <= pset_status;
    end
    if (move) begin
      out_value  <= pend_value;
      out_status <= pend_status;
    end
  end

  assign rsp.valid      = ovalid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;

  `TSBT_ASSERT_NOW(a_run_write_in_mac, m_we && (state != S_IDLE), state == S_MAC, "matrix write outside butterfly phase")
  `TSBT_ASSERT_NOW(a_level_in_range, state == S_CHK, k < depth, "butterfly level past configured depth")
  `TSBT_ASSERT_NEXT(a_run_starts, accept && (cmd.opcode == OP_RUN), state == S_CHK, "run did not start")
  `TSBT_ASSERT_NOW(a_pending_free, pset, !pvalid || move, "pending result overwritten")

endmodule
`default_nettype wire

// ===== sv/tsbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module tsbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/tsbt_scale.sv =====
// Butterfly scaling pipeline: floor(sum * r * s / 2^33), saturated to Q16.16
`default_nettype none
module tsbt_scale import tsbt_pkg::*; #(
  parameter int TW = 13
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  input  wire signed [SUM_W-1:0]   sum,
  input  wire signed [BF_W-1:0]    r,
  input  wire signed [BF_W-1:0]    s,
  input  wire [TW-1:0]             tag_in,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] result,
  output logic [TW-1:0]            tag_out
);

  localparam int PH_W = PROD_W - 16;
  localparam int M1_W = SUM_W + PH_W;
  localparam int M2_W = SUM_W + 17;
  localparam int T_W  = M1_W + 1;
  localparam int SH_W = T_W - 17;

  logic                     v1;
  logic signed [SUM_W-1:0]  sum1;
  logic signed [PROD_W-1:0] p1;
  logic [TW-1:0]            tag1;
  logic signed [M1_W-1:0]   m1;
  logic signed [M2_W-1:0]   m2;
  logic signed [PH_W-1:0]   ph;
  logic signed [16:0]       pl;
  logic signed [T_W-1:0]    t;
  logic signed [SH_W-1:0]   tsh;

  assign ph = $signed(p1[PROD_W-1:16]);
  assign pl = $signed({1'b0, p1[15:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // Stage one: exact r*s; stage two: split product against the sum
  always_ff @(posedge clk) begin
    sum1    <= sum;
    p1      <= r * s;
    tag1    <= tag_in;
    m1      <= sum1 * ph;
    m2      <= sum1 * pl;
    tag_out <= tag1;
  end

  assign t   = T_W'(m1) + T_W'(m2 >>> 16);
  assign tsh = $signed(t[T_W-1:17]);

  always_comb begin
    if (tsh[SH_W-1:DATA_W-1] != {(SH_W-DATA_W+1){tsh[SH_W-1]}}) begin
      result = tsh[SH_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      result = tsh[DATA_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the two-sided butterfly transform unit: predicts every result and checks it
`default_nettype none
module tb_top;
  import tsbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIZE  = 64;
  localparam int MAX_DEPTH = 6;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int SETTLE_CYCLES  = 24;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_MID   = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;
  localparam int BF_MAX = 131071;
  localparam int BF_MIN = -131072;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
  } outcome_t;

  // Holds the outcomes still owed by the block, oldest first.
  class outcome_board;
    outcome_t owed[$];
    int       mismatches;

    function void note_command(outcome_t o);
      owed.push_back(o);
    endfunction

    function void check_response(outcome_t got);
      outcome_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response beat: read_value=%0d status=%0d",
                   got.read_value, got.status);
        return;
      end
      want = owed.pop_front();
      if (want.read_value !== got.read_value || want.status !== got.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected read_value=%0d status=%0d, got read_value=%0d status=%0d",
                   want.read_value, want.status, got.read_value, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = REG_SIZE;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  tsbt_cmd_if cmd ();
  tsbt_rsp_if rsp ();

  two_sided_butterfly_transform_unit #(.MAX_SIZE(MAX_SIZE), .MAX_DEPTH(MAX_DEPTH)) uut (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .rsp(rsp.source),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  outcome_board board = new();

  // Shadow copy of the block: stores, written flags and registers.
  int  mat_q[MAX_SIZE*MAX_SIZE];
  int  left_q[MAX_SIZE*MAX_DEPTH];
  int  right_q[MAX_SIZE*MAX_DEPTH];
  bit  mat_seen[MAX_SIZE*MAX_SIZE];
  bit  left_seen[MAX_SIZE*MAX_DEPTH];
  bit  right_seen[MAX_SIZE*MAX_DEPTH];
  int  seen_cells[$];
  int  cur_size  = 64;
  int  cur_depth = 1;
  bit  quiet;          // no idling on either side while set

  // floor(sum * p / 2^33), saturated to the 32-bit range
  function automatic int scale_term(longint sum, longint p);
    logic signed [71:0] a, b, full, t;
    a = sum;
    b = p;
    full = a * b;
    t = full >>> 33;
    if (t > 72'sd2147483647) return 32'h7fffffff;
    if (t < -72'sd2147483648) return 32'h80000000;
    return int'(t[31:0]);
  endfunction

  function automatic longint cell_value(int r, int c);
    if (r >= cur_size || c >= cur_size) return 0;
    return mat_q[r*MAX_SIZE + c];
  endfunction

  function automatic longint bf_entry(bit left, int r, int k);
    if (r >= cur_size) return 0;
    return left ? left_q[r*MAX_DEPTH + k] : right_q[r*MAX_DEPTH + k];
  endfunction

  function automatic void put_cell(int r, int c, int v);
    if (r < cur_size && c < cur_size) mat_q[r*MAX_SIZE + c] = v;
  endfunction

  // Apply U^T * A * V level by level, smallest blocks first.
  function automatic void transform_matrix();
    int two, nd, blk, h, ra, rb, ca, cb;
    longint a00, a01, a10, a11, r0, r1, s0, s1;
    two = 1 << cur_depth;
    nd = (cur_size + two - 1) & ~(two - 1);
    for (int k = 0; k < cur_depth; k++) begin
      blk = nd >> (cur_depth - 1 - k);
      h = blk / 2;
      for (int orow = 0; orow < nd; orow += blk)
        for (int ocol = 0; ocol < nd; ocol += blk)
          for (int i = 0; i < h && orow + i < cur_size; i++)
            for (int j = 0; j < h && ocol + j < cur_size; j++) begin
              ra = orow + i; rb = ra + h; ca = ocol + j; cb = ca + h;
              a00 = cell_value(ra, ca); a01 = cell_value(ra, cb);
              a10 = cell_value(rb, ca); a11 = cell_value(rb, cb);
              r0 = bf_entry(1, ra, k); r1 = bf_entry(1, rb, k);
              s0 = bf_entry(0, ca, k); s1 = bf_entry(0, cb, k);
              put_cell(ra, ca, scale_term(a00 + a01 + a10 + a11, r0 * s0));
              put_cell(ra, cb, scale_term(a00 + a10 - a01 - a11, r0 * s1));
              put_cell(rb, ca, scale_term(a00 + a01 - a10 - a11, r1 * s0));
              put_cell(rb, cb, scale_term(a00 + a11 - a01 - a10, r1 * s1));
            end
    end
  endfunction

  function automatic outcome_t predict_command(logic [OPCODE_W-1:0] op, int row, int col,
                                               int data);
    outcome_t o;
    o.read_value = '0;
    o.status = ST_OK;
    case (op)
      OP_LOAD_MAT: begin
        if (row >= cur_size || col >= cur_size) o.status = ST_INDEX;
        else begin
          mat_q[row*MAX_SIZE + col] = data;
          if (!mat_seen[row*MAX_SIZE + col]) seen_cells.push_back(row*MAX_SIZE + col);
          mat_seen[row*MAX_SIZE + col] = 1;
        end
      end
      OP_LOAD_LEFT, OP_LOAD_RIGHT: begin
        if (row >= cur_size || col >= cur_depth) o.status = ST_INDEX;
        else if (data < BF_MIN || data > BF_MAX) o.status = ST_VALUE;
        else if (op == OP_LOAD_LEFT) begin
          left_q[row*MAX_DEPTH + col] = data;
          left_seen[row*MAX_DEPTH + col] = 1;
        end else begin
          right_q[row*MAX_DEPTH + col] = data;
          right_seen[row*MAX_DEPTH + col] = 1;
        end
      end
      OP_RUN: transform_matrix();
      OP_READ: begin
        if (row >= cur_size || col >= cur_size) o.status = ST_INDEX;
        else o.read_value = mat_q[row*MAX_SIZE + col];
      end
      default: o.status = ST_INDEX;
    endcase
    return o;
  endfunction

  // A run may only touch entries that were written.
  function automatic bit run_is_safe();
    for (int r = 0; r < cur_size; r++) begin
      for (int c = 0; c < cur_size; c++)
        if (!mat_seen[r*MAX_SIZE + c]) return 0;
      for (int k = 0; k < cur_depth; k++)
        if (!left_seen[r*MAX_DEPTH + k] || !right_seen[r*MAX_DEPTH + k]) return 0;
    end
    return 1;
  endfunction

  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Response side: stall at random, hold ready steady in quiet stretches.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp.ready <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left <= pick_gap();
    end
  end

  // Check every response beat against the oldest owed outcome.
  always @(posedge clk) begin
    outcome_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.read_value = rsp.read_value;
      got.status = rsp.status;
      board.check_response(got);
    end
  end

  // Watchdog: count cycles without any beat on either channel.
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive one command beat, predict it on acceptance, then maybe idle.
  task automatic issue(logic [OPCODE_W-1:0] op, int row, int col, int data);
    int g;
    cmd.valid <= 1'b1;
    cmd.opcode <= op;
    cmd.row_index <= row[IDX_W-1:0];
    cmd.column_index <= col[IDX_W-1:0];
    cmd.data_value <= data;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    board.note_command(predict_command(op, row, col, data));
    g = pick_gap();
    if (g > 0) begin
      cmd.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drop valid, drain all owed beats, then let a run tail finish.
  task automatic drain();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One write beat, then idle with cfg_wen low so back-to-back writes never collide.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] raw);
    int v;
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= raw;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_SIZE) begin
      v = raw;
      cur_size = (v < 1) ? 1 : (v > MAX_SIZE) ? MAX_SIZE : v;
    end else begin
      v = raw[2:0];
      cur_depth = (v < 1) ? 1 : (v > MAX_DEPTH) ? MAX_DEPTH : v;
    end
    @(posedge clk);
  endtask

  function automatic int random_matrix_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 8) - 4;
      default: return $urandom();
    endcase
  endfunction

  function automatic int random_bf_value();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return BF_MAX;
    if (p == 1) return BF_MIN;
    if (p == 2) return $urandom();
    if (p == 3) return BF_MAX + $urandom_range(1, 4);
    return $urandom_range(0, 2*BF_MAX + 1) + BF_MIN;
  endfunction

  // Fill every entry a run at the current setting reads.
  task automatic preload();
    for (int r = 0; r < cur_size; r++) begin
      for (int c = 0; c < cur_size; c++) issue(OP_LOAD_MAT, r, c, random_matrix_value());
      for (int k = 0; k < cur_depth; k++) begin
        issue(OP_LOAD_LEFT, r, k, $urandom_range(0, 2*BF_MAX + 1) + BF_MIN);
        issue(OP_LOAD_RIGHT, r, k, $urandom_range(0, 2*BF_MAX + 1) + BF_MIN);
      end
    end
  endtask

  // Mostly well-formed loads, reads and runs with random content; some noise.
  task automatic random_traffic(int count);
    int p, r, c, idx;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 99);
      r = $urandom_range(0, cur_size - 1);
      c = $urandom_range(0, cur_size - 1);
      if (p < 28) begin
        issue(OP_LOAD_MAT, r, c, random_matrix_value());
      end else if (p < 46) begin
        issue($urandom_range(0, 1) ? OP_LOAD_LEFT : OP_LOAD_RIGHT, r,
              $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                        : $urandom_range(0, cur_depth - 1),
              random_bf_value());
      end else if (p < 78) begin
        if (!mat_seen[r*MAX_SIZE + c]) begin
          idx = seen_cells[$urandom_range(0, seen_cells.size() - 1)];
          r = idx / MAX_SIZE;
          c = idx % MAX_SIZE;
        end
        if (r < cur_size && c < cur_size) issue(OP_READ, r, c, $urandom());
        else issue(OP_LOAD_MAT, r % cur_size, c % cur_size, random_matrix_value());
      end else if (p < 84) begin
        if (run_is_safe()) issue(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
        else issue(OP_LOAD_MAT, r, c, random_matrix_value());
      end else if (p < 89) begin
        issue(OPCODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
              $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
      end else begin
        // index noise: anything the fields allow, reads only where it stays harmless
        r = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
        case ($urandom_range(0, 3))
          0: issue(OP_LOAD_MAT, r, c, $urandom());
          1: issue(OP_LOAD_LEFT, r, c, $urandom());
          2: issue(OP_LOAD_RIGHT, r, c, random_bf_value());
          default:
            if (r >= cur_size || c >= cur_size || mat_seen[r*MAX_SIZE + c])
              issue(OP_READ, r, c, $urandom());
            else issue(OP_LOAD_MAT, r, c, $urandom());
        endcase
      end
    end
  endtask

  // Raw register values per phase; out-of-range ones exercise clamping.
  int phase_size[10]  = '{127, 5, 0, 8, 16, 3, 7, 12, 64, 4};
  int phase_depth[10] = '{6, 7, 0, 3, 4, 2, 5, 6, 1, 2};

  initial begin
    quiet = 0;
    cmd.valid = 1'b0;
    cmd.opcode = OP_RUN;
    cmd.row_index = '0;
    cmd.column_index = '0;
    cmd.data_value = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, butterfly index and value errors and unused opcodes at the reset setting (64 x 64, depth 1).
    issue(OP_LOAD_MAT, 0, 0, 32'h7fffffff);
    issue(OP_LOAD_MAT, 63, 63, 32'h80000000);
    issue(OP_LOAD_MAT, 0, 63, -1);
    issue(OP_READ, 0, 0, 0);
    issue(OP_READ, 63, 63, 0);
    issue(OP_READ, 0, 63, 0);
    issue(OP_LOAD_LEFT, 63, 0, BF_MAX);
    issue(OP_LOAD_RIGHT, 0, 0, BF_MIN);
    issue(OP_LOAD_LEFT, 0, 1, 0);             // level past depth
    issue(OP_LOAD_RIGHT, 63, 63, BF_MAX + 1);  // index checked before value
    issue(OP_LOAD_RIGHT, 1, 0, BF_MAX + 1);    // value too large
    issue(OP_LOAD_LEFT, 1, 0, BF_MIN - 1);     // value too small
    issue(OP_UNUSED_FIRST, 0, 0, 0);
    issue(OP_UNUSED_MID, 63, 63, -1);
    issue(OP_UNUSED_LAST, 21, 42, 32'h55555555);
    drain();

    // Directed: saturating 2 x 2 run.
    write_reg(REG_SIZE, 7'd2);
    write_reg(REG_DEPTH, 7'd1);
    issue(OP_LOAD_MAT, 0, 0, 32'h7fffffff);
    issue(OP_LOAD_MAT, 0, 1, 32'h7fffffff);
    issue(OP_LOAD_MAT, 1, 0, 32'h7fffffff);
    issue(OP_LOAD_MAT, 1, 1, 32'h80000000);
    issue(OP_LOAD_LEFT, 0, 0, BF_MAX);
    issue(OP_LOAD_LEFT, 1, 0, BF_MIN);
    issue(OP_LOAD_RIGHT, 0, 0, BF_MIN);
    issue(OP_LOAD_RIGHT, 1, 0, BF_MAX);
    issue(OP_RUN, 0, 0, 0);
    issue(OP_READ, 0, 0, 0);
    issue(OP_READ, 0, 1, 0);
    issue(OP_READ, 1, 0, 0);
    issue(OP_READ, 1, 1, 0);
    issue(OP_READ, 2, 0, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_SIZE, CFG_W'(phase_size[ph]));
      write_reg(REG_DEPTH, CFG_W'(phase_depth[ph]));
      quiet = (ph % 3 == 1);
      // full-size stores are too large to fill; in those phases no run is issued
      if (cur_size <= 16) preload();
      random_traffic(ph == 8 ? 20 : 28);
      quiet = 0;
      random_traffic(10);
      drain();
    end

    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== two_sided_butterfly_transform_unit.f =====
+incdir+sv
sv/tsbt_pkg.sv
sv/tsbt_channels.sv
sv/tsbt_ram.sv
sv/tsbt_scale.sv
sv/two_sided_butterfly_transform_unit.sv
dv/tb_top.sv
